>>> sv/bdphc_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the two-button debounce and press classifier.
// Used by bdphc_debounce and button_debounce_press_hold_classifier.
package bdphc_pkg;

  localparam int unsigned DebounceW = 8;
  localparam int unsigned HoldW     = 16;
  localparam int unsigned CfgAddrW  = 2;
  localparam int unsigned CfgDataW  = 16;

  localparam logic [DebounceW-1:0] DebounceRst = 8'd2;
  localparam logic [HoldW-1:0]     HoldRst     = 16'd250;
  localparam logic                 ActiveRst   = 1'b0;

  typedef enum logic [CfgAddrW-1:0] {
    REG_DEBOUNCE_TICKS = 2'd0,
    REG_HOLD_TICKS     = 2'd1,
    REG_ACTIVE_LEVEL   = 2'd2
  } cfg_idx_e;

  // Result of one debounce step for one button
  typedef struct packed {
    logic flip;    // new stable level accepted this tick
    logic stable;  // stable pressed state after this tick
  } deb_t;

endpackage

>>> sv/bdphc_debounce.sv
`timescale 1ns / 1ps
// Debounce filter for one button: stable level plus disagreement counter.
// Depends on bdphc_pkg for widths and the deb_t result struct.
module bdphc_debounce (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             en_i,
  input  logic                             raw_i,
  input  logic                             force_i,
  input  logic [bdphc_pkg::DebounceW-1:0]  ticks_i,
  output bdphc_pkg::deb_t                  res_o
);

  logic                            stable_q, stable_d;
  logic [bdphc_pkg::DebounceW-1:0] count_q, count_d;
  logic                            stable_pre;
  logic [bdphc_pkg::DebounceW-1:0] count_inc;

  // first tick after reset: a pressed button starts out stable pressed
  assign stable_pre = force_i | stable_q;
  assign count_inc  = (&count_q) ? count_q : count_q + 1'b1;

  always_comb begin
    stable_d   = stable_pre;
    count_d    = count_inc;
    res_o.flip = 1'b0;
    if (raw_i == stable_pre) begin
      count_d = '0;
    end else if (count_inc >= ticks_i) begin
      stable_d   = raw_i;
      count_d    = '0;
      res_o.flip = 1'b1;
    end
    res_o.stable = stable_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stable_q <= 1'b0;
      count_q  <= '0;
    end else if (en_i) begin
      stable_q <= stable_d;
      count_q  <= count_d;
    end
  end

endmodule

>>> sv/button_debounce_press_hold_classifier.sv
`timescale 1ns / 1ps
// Two-button debounce and short-press / long-hold / press-edge classifier.
// Depends on bdphc_pkg and bdphc_debounce.
//
// Usage:
//   Each slave-side word is one poll tick carrying the raw pin levels of the
//   setup and mute buttons. Every tick yields exactly one master-side word with
//   the event flags and the debounced pressed states after that tick.
//   The button state advances in the cycle the word is accepted; the result
//   sits in an output register and shows up on the master side in the next cycle.
//   One word per cycle is sustained: s_axis_tready stays high while the output
//   register is empty or being drained in the same cycle.
//   When the receiver stalls, the result holds in the output register and
//   s_axis_tready drops until it is taken; no tick is lost.
//   Reset clears the output register and puts both buttons released and armed,
//   with registers at debounce 2 ticks, hold 250 ticks, active-low pins.
//   The first tick after reset takes a pressed button as stable and disarmed,
//   so its first release only re-arms it.
//   Configuration writes take effect on the next accepted tick; write only
//   while no tick is in flight.
module button_debounce_press_hold_classifier #(
  parameter int unsigned HOLD_COUNT_BITS = 16
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [bdphc_pkg::CfgAddrW-1:0]  cfg_addr_i,
  input  logic [bdphc_pkg::CfgDataW-1:0]  cfg_wdata_i,
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  // [0] setup_level, [1] mute_level, [7:2] zero
  input  logic [7:0]                      s_axis_tdata,
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  // [0] setup_short_press, [1] setup_long_hold, [2] mute_press,
  // [3] setup_pressed, [4] mute_pressed, [7:5] zero
  output logic [7:0]                      m_axis_tdata
);

  localparam int unsigned CmpW = (HOLD_COUNT_BITS > bdphc_pkg::HoldW) ?
                                 HOLD_COUNT_BITS : bdphc_pkg::HoldW;

  // configuration registers
  logic [bdphc_pkg::DebounceW-1:0] debounce_ticks_q;
  logic [bdphc_pkg::HoldW-1:0]     hold_ticks_q;
  logic                            active_level_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      debounce_ticks_q <= bdphc_pkg::DebounceRst;
      hold_ticks_q     <= bdphc_pkg::HoldRst;
      active_level_q   <= bdphc_pkg::ActiveRst;
    end else if (cfg_we_i) begin
      unique case (bdphc_pkg::cfg_idx_e'(cfg_addr_i))
        bdphc_pkg::REG_DEBOUNCE_TICKS:
          debounce_ticks_q <= cfg_wdata_i[bdphc_pkg::DebounceW-1:0];
        bdphc_pkg::REG_HOLD_TICKS:
          hold_ticks_q <= cfg_wdata_i[bdphc_pkg::HoldW-1:0];
        bdphc_pkg::REG_ACTIVE_LEVEL:
          active_level_q <= cfg_wdata_i[0];
        default: ;
      endcase
    end
  end

  // handshake and output register
  logic       accept;
  logic       out_valid_q;
  logic [4:0] out_data_q, out_data_d;

  assign s_axis_tready = !out_valid_q || m_axis_tready;
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {3'b000, out_data_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      out_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      out_data_q <= out_data_d;
    end
  end

  // button state
  logic                       started_q;
  logic                       setup_armed_q, setup_armed_d;
  logic                       setup_done_q, setup_done_d;
  logic [HOLD_COUNT_BITS-1:0] setup_held_q, setup_held_d;
  logic                       mute_armed_q, mute_armed_d;

  logic setup_raw, mute_raw;
  logic setup_force, mute_force;
  logic setup_armed_pre, mute_armed_pre;
  bdphc_pkg::deb_t setup_deb, mute_deb;

  logic [HOLD_COUNT_BITS-1:0] held_base;
  logic                       done_base;
  logic                       short_press, long_hold, mute_press;

  assign setup_raw  = (s_axis_tdata[0] == active_level_q);
  assign mute_raw   = (s_axis_tdata[1] == active_level_q);
  assign setup_force = !started_q && setup_raw;
  assign mute_force  = !started_q && mute_raw;
  assign setup_armed_pre = setup_armed_q && !setup_force;
  assign mute_armed_pre  = mute_armed_q && !mute_force;

  bdphc_debounce u_setup_deb (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (accept),
    .raw_i   (setup_raw),
    .force_i (setup_force),
    .ticks_i (debounce_ticks_q),
    .res_o   (setup_deb)
  );

  bdphc_debounce u_mute_deb (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (accept),
    .raw_i   (mute_raw),
    .force_i (mute_force),
    .ticks_i (debounce_ticks_q),
    .res_o   (mute_deb)
  );

  // setup: any accepted level change re-arms and restarts the hold
  always_comb begin
    short_press   = setup_deb.flip && !setup_deb.stable && setup_armed_pre &&
                    !setup_done_q;
    setup_armed_d = setup_armed_pre || setup_deb.flip;
    held_base     = setup_deb.flip ? '0 : setup_held_q;
    done_base     = setup_deb.flip ? 1'b0 : setup_done_q;
    setup_held_d  = held_base;
    setup_done_d  = done_base;
    long_hold     = 1'b0;
    if (setup_deb.stable && setup_armed_d) begin
      if (!(&held_base)) begin
        setup_held_d = held_base + 1'b1;
      end
      if (!done_base &&
          (CmpW'(setup_held_d) >= CmpW'(hold_ticks_q))) begin
        setup_done_d = 1'b1;
        long_hold    = 1'b1;
      end
    end
  end

  // mute: press edge reports only when armed
  assign mute_press   = mute_deb.flip && mute_deb.stable && mute_armed_pre;
  assign mute_armed_d = mute_armed_pre || mute_deb.flip;

  assign out_data_d = {mute_deb.stable, setup_deb.stable, mute_press, long_hold,
                       short_press};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      started_q     <= 1'b0;
      setup_armed_q <= 1'b1;
      setup_done_q  <= 1'b0;
      setup_held_q  <= '0;
      mute_armed_q  <= 1'b1;
    end else if (accept) begin
      started_q     <= 1'b1;
      setup_armed_q <= setup_armed_d;
      setup_done_q  <= setup_done_d;
      setup_held_q  <= setup_held_d;
      mute_armed_q  <= mute_armed_d;
    end
  end

endmodule

>>> bench/bdphc_checker.sv
`timescale 1ns / 1ps
// Scoreboard for button_debounce_press_hold_classifier: mirrors the button state,
// predicts one result word per accepted tick and compares the master-side words.
// Depends on bdphc_pkg.
module bdphc_checker #(
  parameter int unsigned HOLD_COUNT_BITS = 16
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [bdphc_pkg::CfgAddrW-1:0] cfg_addr_i,
  input  logic [bdphc_pkg::CfgDataW-1:0] cfg_wdata_i,
  input  logic                           s_tvalid_i,
  input  logic                           s_tready_i,
  // [0] setup_level, [1] mute_level, [7:2] zero
  input  logic [7:0]                     s_tdata_i,
  input  logic                           m_tvalid_i,
  input  logic                           m_tready_i,
  // [0] setup_short_press, [1] setup_long_hold, [2] mute_press,
  // [3] setup_pressed, [4] mute_pressed, [7:5] zero
  input  logic [7:0]                     m_tdata_i,
  output int                             fail_count_o,
  output int                             pending_o
);

  typedef struct packed {
    logic mute_pressed;
    logic setup_pressed;
    logic mute_press;
    logic long_hold;
    logic short_press;
  } tick_flags_t;

  typedef struct packed {
    logic                            flip;
    logic                            stable;
    logic [bdphc_pkg::DebounceW-1:0] count;
  } deb_next_t;

  logic [bdphc_pkg::DebounceW-1:0] debounce_ticks;
  logic [bdphc_pkg::HoldW-1:0]     hold_ticks;
  logic                            active_lvl;

  logic                            started;
  logic                            setup_stable;
  logic                            setup_armed;
  logic                            setup_hold_done;
  logic [bdphc_pkg::DebounceW-1:0] setup_bounce;
  logic [HOLD_COUNT_BITS-1:0]      setup_held;
  logic                            mute_stable;
  logic                            mute_armed;
  logic [bdphc_pkg::DebounceW-1:0] mute_bounce;

  tick_flags_t                     expected_flags_q[$];
  int                              results_seen;

  function automatic deb_next_t debounce_step(logic raw, logic stable,
                                              logic [bdphc_pkg::DebounceW-1:0] count);
    deb_next_t d;
    d.flip   = 1'b0;
    d.stable = stable;
    d.count  = count;
    if (raw == stable) begin
      d.count = '0;
    end else begin
      if (d.count != '1) d.count = d.count + 1'b1;
      if (d.count >= debounce_ticks) begin
        d.stable = raw;
        d.count  = '0;
        d.flip   = 1'b1;
      end
    end
    return d;
  endfunction

  // Advance the mirrored button state by one poll tick.
  function automatic tick_flags_t classify_tick(logic setup_lvl, logic mute_lvl);
    tick_flags_t r;
    deb_next_t   d;
    logic        setup_raw;
    logic        mute_raw;
    r         = '0;
    setup_raw = (setup_lvl == active_lvl);
    mute_raw  = (mute_lvl == active_lvl);

    // a button already down at the first tick is taken as pressed but disarmed
    if (!started) begin
      started = 1'b1;
      if (setup_raw) begin
        setup_stable = 1'b1;
        setup_armed  = 1'b0;
      end
      if (mute_raw) begin
        mute_stable = 1'b1;
        mute_armed  = 1'b0;
      end
    end

    d            = debounce_step(setup_raw, setup_stable, setup_bounce);
    setup_stable = d.stable;
    setup_bounce = d.count;
    if (d.flip) begin
      if (!setup_stable && setup_armed && !setup_hold_done) r.short_press = 1'b1;
      setup_armed     = 1'b1;
      setup_held      = '0;
      setup_hold_done = 1'b0;
    end
    if (setup_stable && setup_armed) begin
      if (setup_held != '1) setup_held = setup_held + 1'b1;
      if (!setup_hold_done && setup_held >= hold_ticks) begin
        setup_hold_done = 1'b1;
        r.long_hold     = 1'b1;
      end
    end

    d           = debounce_step(mute_raw, mute_stable, mute_bounce);
    mute_stable = d.stable;
    mute_bounce = d.count;
    if (d.flip) begin
      if (mute_stable && mute_armed) r.mute_press = 1'b1;
      mute_armed = 1'b1;
    end

    r.setup_pressed = setup_stable;
    r.mute_pressed  = mute_stable;
    return r;
  endfunction

  task automatic report_mismatch(input string msg);
    $display("mismatch at result %0d: %s", results_seen, msg);
    fail_count_o = fail_count_o + 1;
  endtask

  task automatic check_flag(input string name, input logic got, input logic want);
    if (got !== want) report_mismatch($sformatf("%s got %b want %b", name, got, want));
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    tick_flags_t got;
    tick_flags_t want;
    if (!rst_ni) begin
      debounce_ticks  = bdphc_pkg::DebounceRst;
      hold_ticks      = bdphc_pkg::HoldRst;
      active_lvl      = bdphc_pkg::ActiveRst;
      started         = 1'b0;
      setup_stable    = 1'b0;
      setup_armed     = 1'b1;
      setup_hold_done = 1'b0;
      setup_bounce    = '0;
      setup_held      = '0;
      mute_stable     = 1'b0;
      mute_armed      = 1'b1;
      mute_bounce     = '0;
      expected_flags_q.delete();
      results_seen    = 0;
      fail_count_o    = 0;
    end else begin
      if (m_tvalid_i && m_tready_i) begin
        got = tick_flags_t'(m_tdata_i[4:0]);
        if (expected_flags_q.size() == 0) begin
          report_mismatch($sformatf("unexpected word %h", m_tdata_i));
        end else begin
          want = expected_flags_q.pop_front();
          check_flag("setup_short_press", got.short_press, want.short_press);
          check_flag("setup_long_hold", got.long_hold, want.long_hold);
          check_flag("mute_press", got.mute_press, want.mute_press);
          check_flag("setup_pressed", got.setup_pressed, want.setup_pressed);
          check_flag("mute_pressed", got.mute_pressed, want.mute_pressed);
        end
        results_seen = results_seen + 1;
      end
      if (s_tvalid_i && s_tready_i) begin
        expected_flags_q.push_back(classify_tick(s_tdata_i[0], s_tdata_i[1]));
      end
      if (cfg_we_i) begin
        case (bdphc_pkg::cfg_idx_e'(cfg_addr_i))
          bdphc_pkg::REG_DEBOUNCE_TICKS:
            debounce_ticks = cfg_wdata_i[bdphc_pkg::DebounceW-1:0];
          bdphc_pkg::REG_HOLD_TICKS:
            hold_ticks     = cfg_wdata_i[bdphc_pkg::HoldW-1:0];
          bdphc_pkg::REG_ACTIVE_LEVEL:
            active_lvl     = cfg_wdata_i[0];
          default: ;
        endcase
      end
    end
    pending_o = expected_flags_q.size();
  end

endmodule

>>> bench/tb.sv
`timescale 1ns / 1ps
// Top of the bench: drives poll ticks and register writes into the classifier
// and gives the verdict. Depends on bdphc_pkg, bdphc_checker and the block.
module tb;

  localparam int HoldBits   = 16;
  localparam int CycleLimit = 400000;
  localparam int SettleCyc  = 4;

  logic                           clk_i         = 1'b0;
  logic                           rst_ni        = 1'b0;
  logic                           cfg_we        = 1'b0;
  logic [bdphc_pkg::CfgAddrW-1:0] cfg_addr      = '0;
  logic [bdphc_pkg::CfgDataW-1:0] cfg_wdata     = '0;
  logic                           s_axis_tvalid = 1'b0;
  logic [7:0]                     s_axis_tdata  = '0;
  logic                           m_axis_tready = 1'b0;
  logic                           s_axis_tready;
  logic                           m_axis_tvalid;
  logic [7:0]                     m_axis_tdata;

  int                  fail_count;
  int                  pending;
  int                  cycle_count    = 0;
  int                  sender_idle_pct = 0;
  int                  recv_stall_pct  = 0;

  logic [bdphc_pkg::DebounceW-1:0] cur_debounce = bdphc_pkg::DebounceRst;
  logic [bdphc_pkg::HoldW-1:0]     cur_hold     = bdphc_pkg::HoldRst;
  logic                            cur_active   = bdphc_pkg::ActiveRst;

  // per-button gesture generator: index 0 setup, 1 mute
  int   seg_left[2]    = '{0, 0};
  int   seg_bounce[2]  = '{0, 0};
  logic seg_pressed[2] = '{1'b0, 1'b0};
  logic seg_noise[2]   = '{1'b0, 1'b0};

  button_debounce_press_hold_classifier #(
    .HOLD_COUNT_BITS(HoldBits)
  ) dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we),
    .cfg_addr_i    (cfg_addr),
    .cfg_wdata_i   (cfg_wdata),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  bdphc_checker #(
    .HOLD_COUNT_BITS(HoldBits)
  ) u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we),
    .cfg_addr_i   (cfg_addr),
    .cfg_wdata_i  (cfg_wdata),
    .s_tvalid_i   (s_axis_tvalid),
    .s_tready_i   (s_axis_tready),
    .s_tdata_i    (s_axis_tdata),
    .m_tvalid_i   (m_axis_tvalid),
    .m_tready_i   (m_axis_tready),
    .m_tdata_i    (m_axis_tdata),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  task automatic send_tick(input logic setup_lvl, input logic mute_lvl);
    while ($urandom_range(99) < sender_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {6'b0, mute_lvl, setup_lvl};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
  endtask

  // Hold the sender until every predicted word has come back.
  task automatic drain_results();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
  endtask

  task automatic set_config(input logic [bdphc_pkg::DebounceW-1:0] deb,
                            input logic [bdphc_pkg::HoldW-1:0] hold,
                            input logic act);
    drain_results();
    repeat (SettleCyc) @(posedge clk_i);
    cfg_we    <= 1'b1;
    cfg_addr  <= bdphc_pkg::REG_DEBOUNCE_TICKS;
    cfg_wdata <= bdphc_pkg::CfgDataW'(deb);
    @(posedge clk_i);
    cfg_addr  <= bdphc_pkg::REG_HOLD_TICKS;
    cfg_wdata <= hold;
    @(posedge clk_i);
    cfg_addr  <= bdphc_pkg::REG_ACTIVE_LEVEL;
    cfg_wdata <= bdphc_pkg::CfgDataW'(act);
    @(posedge clk_i);
    cfg_we       <= 1'b0;
    cur_debounce = deb;
    cur_hold     = hold;
    cur_active   = act;
  endtask

  // Next pin level: alternating press/release gestures with edge bounce,
  // rare glitches, and now and then a burst of pure noise.
  function automatic logic next_pin(int btn, int seg_max);
    logic pressed;
    if (seg_left[btn] == 0) begin
      seg_noise[btn]   = ($urandom_range(99) < 15);
      seg_pressed[btn] = ~seg_pressed[btn];
      seg_left[btn]    = seg_noise[btn] ? $urandom_range(10, 1) : $urandom_range(seg_max, 1);
      seg_bounce[btn]  = $urandom_range(4);
    end
    seg_left[btn] = seg_left[btn] - 1;
    if (seg_noise[btn]) begin
      pressed = 1'($urandom_range(1));
    end else if (seg_bounce[btn] > 0) begin
      seg_bounce[btn] = seg_bounce[btn] - 1;
      pressed = 1'($urandom_range(1));
    end else if (cur_debounce <= 8 && $urandom_range(49) == 0) begin
      pressed = ~seg_pressed[btn];
    end else begin
      pressed = seg_pressed[btn];
    end
    return pressed ? cur_active : ~cur_active;
  endfunction

  task automatic run_phase(input logic [bdphc_pkg::DebounceW-1:0] deb,
                           input logic [bdphc_pkg::HoldW-1:0] hold,
                           input logic act, input int idle_pct, input int stall_pct,
                           input int items);
    int setup_max;
    int mute_max;
    set_config(deb, hold, act);
    sender_idle_pct = idle_pct;
    recv_stall_pct  = stall_pct;
    setup_max = ((hold > 300) ? 300 : int'(hold)) + int'(deb) + 10;
    mute_max  = int'(deb) + 20;
    for (int n = 0; n < items; n++) begin
      if ($urandom_range(199) == 0) drain_results();
      send_tick(next_pin(0, setup_max), next_pin(1, mute_max));
    end
  endtask

  initial begin
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset values: debounce 2, hold 250, active low
    send_tick(1'b0, 1'b0);  // both down from the start: pressed, disarmed
    send_tick(1'b1, 1'b1);
    send_tick(1'b1, 1'b1);  // first release only re-arms
    send_tick(1'b0, 1'b0);
    send_tick(1'b0, 1'b0);  // armed press: mute event, setup starts counting
    send_tick(1'b1, 1'b1);
    send_tick(1'b1, 1'b1);  // release before hold: short press

    // zero debounce and zero hold, active high
    set_config(8'd0, 16'd0, 1'b1);
    send_tick(1'b1, 1'b0);  // press and long hold on one tick
    send_tick(1'b1, 1'b1);
    send_tick(1'b0, 1'b0);  // release after hold fired: no short press
    send_tick(1'b0, 1'b1);
    send_tick(1'b0, 1'b0);

    // lower the hold threshold under a running count
    set_config(8'd1, 16'hFFFF, 1'b1);
    repeat (5) send_tick(1'b1, 1'b0);
    set_config(8'd1, 16'd3, 1'b1);
    send_tick(1'b1, 1'b0);
    send_tick(1'b0, 1'b0);

    run_phase(8'd2,   16'd250,   1'b0, 0,  0,  180);
    run_phase(8'd1,   16'd5,     1'b1, 70, 0,  80);
    run_phase(8'd0,   16'd1,     1'b0, 0,  70, 80);
    run_phase(8'd255, 16'd0,     1'b1, 6,  6,  270);
    run_phase(8'd3,   16'hFFFF,  1'b0, 0,  0,  60);
    run_phase(8'd7,   16'd20,    1'b1, 70, 70, 60);

    drain_results();
    repeat (SettleCyc) @(posedge clk_i);
    if (fail_count == 0 && pending == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
